// ===== sv/c3t_pkg.sv =====
package c3t_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int POS_W      = 24;
  localparam int PIX_W      = 8;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 24;
  localparam int SUM_W      = 28;
  localparam int CFG_W      = 48;
  localparam int REG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOTTOM  = 3'd4,
    REG_THRESHOLD    = 3'd5,
    REG_OUT_HIGH     = 3'd6,
    REG_OUT_LOW      = 3'd7
  } c3t_reg_e;

  localparam logic [WIDTH_W-1:0]    RST_FRAME_WIDTH  = 12'd640;
  localparam logic [HEIGHT_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0]      RST_COEF_TOP     = 48'd0;
  localparam logic [CFG_W-1:0]      RST_COEF_MID     = 48'd256;
  localparam logic [CFG_W-1:0]      RST_COEF_BOTTOM  = 48'd0;
  localparam logic [SUM_W-1:0]      RST_THRESHOLD    = 28'd32768;
  localparam logic [PIX_W-1:0]      RST_OUT_HIGH     = 8'd255;
  localparam logic [PIX_W-1:0]      RST_OUT_LOW      = 8'd0;

  // one pixel moving into the line store / window
  typedef struct packed {
    logic             valid;
    logic             has_result;
    logic             last;
    logic [3:0]       mask;   // top row c0..c2, then middle row left
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] pix;
  } c3t_req_t;

  typedef struct packed {
    logic       valid;
    logic       has_result;
    logic       last;
    logic [3:0] mask;
  } c3t_tap_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;
  } c3t_res_t;

  typedef logic [2:0][2:0][PIX_W-1:0] c3t_win_t;

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [CFG_W-1:0] row,
                                                        input logic [1:0] col);
    return $signed(row[col*COEF_W +: COEF_W]);
  endfunction

  // taps that fall above the frame top read as zero
  function automatic logic tap_on(input logic [3:0] mask, input int r, input int c);
    logic on;
    on = 1'b1;
    if (r == 0) begin
      on = mask[c];
    end else if (r == 1 && c == 0) begin
      on = mask[3];
    end
    return on;
  endfunction

endpackage

// ===== sv/c3t_if.sv =====
interface c3t_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [c3t_pkg::PIX_W-1:0] pixel_value;

  modport source(output valid, output op, output pixel_value, input ready);
  modport sink(input valid, input op, input pixel_value, output ready);
endinterface

interface c3t_out_if;
  logic                     valid;
  logic                     ready;
  logic [c3t_pkg::PIX_W-1:0] out_pixel;
  logic                     frame_last;

  modport source(output valid, output out_pixel, output frame_last, input ready);
  modport sink(input valid, input out_pixel, input frame_last, output ready);
endinterface

// ===== sv/c3t_ram.sv =====
module c3t_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/c3t_window.sv =====
module c3t_window (
  input  logic              clk,
  input  logic              rst,
  input  c3t_pkg::c3t_req_t req,
  output c3t_pkg::c3t_win_t win,
  output c3t_pkg::c3t_tap_t tap
);

  c3t_pkg::c3t_req_t             s1;
  logic                          s1_fwd;
  logic [c3t_pkg::LINE_W-1:0]    s1_fwd_data;
  logic [c3t_pkg::LINE_W-1:0]    rd_data;
  logic [c3t_pkg::LINE_W-1:0]    mem_word;
  logic [c3t_pkg::LINE_W-1:0]    wr_data;
  logic [c3t_pkg::PIX_W-1:0]     d1;
  logic [c3t_pkg::PIX_W-1:0]     d2;

  // word = {older line, newer line}
  c3t_ram #(
    .WIDTH(c3t_pkg::LINE_W),
    .DEPTH(c3t_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (s1.valid),
    .wr_addr(s1.addr),
    .wr_data(wr_data),
    .rd_en  (req.valid),
    .rd_addr(req.addr),
    .rd_data(rd_data)
  );

  // read issued in the same cycle as the write to the same column sees stale data
  assign mem_word = s1_fwd ? s1_fwd_data : rd_data;
  assign d1       = mem_word[c3t_pkg::PIX_W-1:0];
  assign d2       = mem_word[c3t_pkg::LINE_W-1:c3t_pkg::PIX_W];
  assign wr_data  = {d1, s1.pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1          <= '0;
      s1_fwd      <= 1'b0;
      s1_fwd_data <= '0;
    end else begin
      s1          <= req;
      s1_fwd      <= req.valid && s1.valid && (req.addr == s1.addr);
      s1_fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      tap <= '0;
    end else begin
      tap <= '{valid: s1.valid, has_result: s1.has_result, last: s1.last, mask: s1.mask};
      if (s1.valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= d2;
        win[1][2] <= d1;
        win[2][2] <= s1.pix;
      end
    end
  end

endmodule

// ===== sv/c3t_mac.sv =====
module c3t_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  c3t_pkg::c3t_win_t                  win,
  input  c3t_pkg::c3t_tap_t                  tap,
  input  logic [c3t_pkg::CFG_W-1:0]          coef_top_row,
  input  logic [c3t_pkg::CFG_W-1:0]          coef_mid_row,
  input  logic [c3t_pkg::CFG_W-1:0]          coef_bottom_row,
  input  logic signed [c3t_pkg::SUM_W-1:0]   level_threshold,
  input  logic [c3t_pkg::PIX_W-1:0]          out_high,
  input  logic [c3t_pkg::PIX_W-1:0]          out_low,
  output logic                               push,
  output c3t_pkg::c3t_res_t                  push_data
);

  logic [2:0][c3t_pkg::CFG_W-1:0]       rows;
  logic signed [c3t_pkg::PROD_W-1:0]    prod [3][3];
  logic                                 p_valid;
  logic                                 p_last;
  logic signed [c3t_pkg::SUM_W-1:0]     row_sum [3];
  logic                                 r_valid;
  logic                                 r_last;
  logic signed [c3t_pkg::SUM_W-1:0]     total;

  assign rows[0] = coef_top_row;
  assign rows[1] = coef_mid_row;
  assign rows[2] = coef_bottom_row;

  // stage: nine products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= tap.valid && tap.has_result;
    end
  end

  always_ff @(posedge clk) begin
    p_last <= tap.last;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (c3t_pkg::tap_on(tap.mask, r, c)) begin
          prod[r][c] <= c3t_pkg::PROD_W'(c3t_pkg::coef_at(rows[r], 2'(c)) *
                                         $signed({1'b0, win[r][c]}));
        end else begin
          prod[r][c] <= '0;
        end
      end
    end
  end

  // stage: row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    r_last <= p_last;
    for (int r = 0; r < 3; r++) begin
      row_sum[r] <= c3t_pkg::SUM_W'(prod[r][0]) + c3t_pkg::SUM_W'(prod[r][1]) +
                    c3t_pkg::SUM_W'(prod[r][2]);
    end
  end

  // final add and threshold go straight into the output queue
  assign total                = row_sum[0] + row_sum[1] + row_sum[2];
  assign push                 = r_valid;
  assign push_data.out_pixel  = (total >= level_threshold) ? out_high : out_low;
  assign push_data.frame_last = r_last;

endmodule

// ===== sv/c3t_fifo.sv =====
module c3t_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  c3t_pkg::c3t_res_t push_data,
  c3t_out_if.source         res_out
);

  c3t_pkg::c3t_res_t              mem [c3t_pkg::FIFO_DEPTH];
  logic [c3t_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [c3t_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [c3t_pkg::CNT_W-1:0]      count;
  logic                           pop;

  assign res_out.valid      = (count != '0);
  assign res_out.out_pixel  = mem[rd_ptr].out_pixel;
  assign res_out.frame_last = mem[rd_ptr].frame_last;
  assign pop                = res_out.valid && res_out.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // upstream credit keeps count within depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + c3t_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + c3t_pkg::FIFO_AW'(1);
      end
      count <= count + c3t_pkg::CNT_W'(push) - c3t_pkg::CNT_W'(pop);
    end
  end

endmodule

// ===== sv/conv3x3_threshold_unit.sv =====
// Streaming 3x3 convolution with threshold. Pixel words enter in raster order and the unit
// takes one word per clock. Two image lines sit in a single 2048 x 16 line RAM that is read
// and rewritten once per pixel (forwarding covers a one-pixel-wide frame). The result for a
// pixel leaves once the pixel W+1 places later (or a drain word) has entered and gone
// through the window, product and row-sum registers and the output queue. Results wait in
// an 8-entry output queue; input ready drops only while 8 results are accepted but not yet
// taken, so with the output side ready the rate is one word per clock. Frame width and height
// are sampled when a frame's first pixel arrives; coefficients, threshold and output levels
// apply at once. The frame's final result carries frame_last.
module conv3x3_threshold_unit (
  input  logic                              clk,
  input  logic                              rst,
  c3t_in_if.sink                            pix_in,
  c3t_out_if.source                         res_out,
  input  logic                              cfg_wr,
  input  logic [c3t_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [c3t_pkg::CFG_W-1:0]         cfg_data
);

  logic [c3t_pkg::WIDTH_W-1:0]       frame_width;
  logic [c3t_pkg::HEIGHT_W-1:0]      frame_height;
  logic [c3t_pkg::CFG_W-1:0]         coef_top_row;
  logic [c3t_pkg::CFG_W-1:0]         coef_mid_row;
  logic [c3t_pkg::CFG_W-1:0]         coef_bottom_row;
  logic signed [c3t_pkg::SUM_W-1:0]  level_threshold;
  logic [c3t_pkg::PIX_W-1:0]         out_high;
  logic [c3t_pkg::PIX_W-1:0]         out_low;

  logic [c3t_pkg::WIDTH_W-1:0]       cur_w;
  logic [c3t_pkg::POS_W-1:0]         cur_n;
  logic [c3t_pkg::POS_W-1:0]         in_position;
  logic [c3t_pkg::COL_W-1:0]         col;
  logic [c3t_pkg::CNT_W-1:0]         pending;

  logic [c3t_pkg::WIDTH_W-1:0]       clamp_w;
  logic [c3t_pkg::HEIGHT_W-1:0]      clamp_h;
  logic [c3t_pkg::WIDTH_W-1:0]       w_eff;
  logic [c3t_pkg::POS_W-1:0]         w_ext;
  logic [c3t_pkg::POS_W-1:0]         w_two;
  logic [c3t_pkg::WIDTH_W-1:0]       col_inc;
  logic                              frame_start;
  logic                              in_frame;
  logic                              accept;
  logic                              go;
  logic                              has_result;
  logic                              last;
  logic                              pop;

  c3t_pkg::c3t_req_t                 req;
  c3t_pkg::c3t_win_t                 win;
  c3t_pkg::c3t_tap_t                 tap;
  logic                              push;
  c3t_pkg::c3t_res_t                 push_data;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= c3t_pkg::RST_FRAME_WIDTH;
      frame_height    <= c3t_pkg::RST_FRAME_HEIGHT;
      coef_top_row    <= c3t_pkg::RST_COEF_TOP;
      coef_mid_row    <= c3t_pkg::RST_COEF_MID;
      coef_bottom_row <= c3t_pkg::RST_COEF_BOTTOM;
      level_threshold <= c3t_pkg::RST_THRESHOLD;
      out_high        <= c3t_pkg::RST_OUT_HIGH;
      out_low         <= c3t_pkg::RST_OUT_LOW;
    end else if (cfg_wr) begin
      case (c3t_pkg::c3t_reg_e'(cfg_index))
        c3t_pkg::REG_FRAME_WIDTH:  frame_width     <= cfg_data[c3t_pkg::WIDTH_W-1:0];
        c3t_pkg::REG_FRAME_HEIGHT: frame_height    <= cfg_data[c3t_pkg::HEIGHT_W-1:0];
        c3t_pkg::REG_COEF_TOP:     coef_top_row    <= cfg_data;
        c3t_pkg::REG_COEF_MID:     coef_mid_row    <= cfg_data;
        c3t_pkg::REG_COEF_BOTTOM:  coef_bottom_row <= cfg_data;
        c3t_pkg::REG_THRESHOLD:    level_threshold <= $signed(cfg_data[c3t_pkg::SUM_W-1:0]);
        c3t_pkg::REG_OUT_HIGH:     out_high        <= cfg_data[c3t_pkg::PIX_W-1:0];
        c3t_pkg::REG_OUT_LOW:      out_low         <= cfg_data[c3t_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    clamp_w = frame_width;
    if (frame_width == '0) begin
      clamp_w = c3t_pkg::WIDTH_W'(1);
    end else if (frame_width > c3t_pkg::WIDTH_W'(c3t_pkg::MAX_WIDTH)) begin
      clamp_w = c3t_pkg::WIDTH_W'(c3t_pkg::MAX_WIDTH);
    end
    clamp_h = (frame_height == '0) ? c3t_pkg::HEIGHT_W'(1) : frame_height;
  end

  // cur_w / cur_n are stale on a frame's first word; nothing there depends on them
  assign frame_start = (in_position == '0);
  assign w_eff       = frame_start ? clamp_w : cur_w;
  assign w_ext       = c3t_pkg::POS_W'(w_eff);
  assign w_two       = w_ext << 1;
  assign in_frame    = frame_start || (in_position < cur_n);
  assign accept      = pix_in.valid && pix_in.ready;
  // a drain while pixels are still expected is dropped
  assign go          = accept && !(pix_in.op && in_frame);
  assign has_result  = in_position >= (w_ext + c3t_pkg::POS_W'(1));
  assign last        = has_result && (in_position >= (cur_n + w_ext));
  assign col_inc     = c3t_pkg::WIDTH_W'(col) + c3t_pkg::WIDTH_W'(1);

  assign pop          = res_out.valid && res_out.ready;
  assign pix_in.ready = (pending < c3t_pkg::CNT_W'(c3t_pkg::FIFO_DEPTH));

  always_comb begin
    req.valid      = go;
    req.has_result = has_result;
    req.last       = last;
    req.mask[0]    = in_position >= (w_two + c3t_pkg::POS_W'(2));
    req.mask[1]    = in_position >= (w_two + c3t_pkg::POS_W'(1));
    req.mask[2]    = in_position >= w_two;
    req.mask[3]    = in_position >= (w_ext + c3t_pkg::POS_W'(2));
    req.addr       = col;
    // past the last pixel everything enters as zero
    req.pix        = in_frame ? pix_in.pixel_value : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_position <= '0;
      col         <= '0;
      cur_w       <= c3t_pkg::WIDTH_W'(640);
      cur_n       <= c3t_pkg::POS_W'(640 * 480);
      pending     <= '0;
    end else begin
      if (go) begin
        if (frame_start) begin
          cur_w <= clamp_w;
          cur_n <= c3t_pkg::POS_W'(clamp_w * clamp_h);
        end
        if (last) begin
          in_position <= '0;
          col         <= '0;
        end else begin
          in_position <= in_position + c3t_pkg::POS_W'(1);
          col         <= (col_inc == w_eff) ? '0 : col_inc[c3t_pkg::COL_W-1:0];
        end
      end
      pending <= pending + c3t_pkg::CNT_W'(go && has_result) - c3t_pkg::CNT_W'(pop);
    end
  end

  c3t_window u_window (
    .clk(clk),
    .rst(rst),
    .req(req),
    .win(win),
    .tap(tap)
  );

  c3t_mac u_mac (
    .clk            (clk),
    .rst            (rst),
    .win            (win),
    .tap            (tap),
    .coef_top_row   (coef_top_row),
    .coef_mid_row   (coef_mid_row),
    .coef_bottom_row(coef_bottom_row),
    .level_threshold(level_threshold),
    .out_high       (out_high),
    .out_low        (out_low),
    .push           (push),
    .push_data      (push_data)
  );

  c3t_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .res_out  (res_out)
  );

endmodule

// ===== sv/c3t_checker.sv =====
module c3t_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [c3t_pkg::PIX_W-1:0] out_pixel,
  input logic                      frame_last
);

  logic [31:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 32'(in_valid && in_ready) - 32'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(frame_last))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> outstanding != '0)
    else $error("result word without a preceding input word");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> outstanding >= 32'(c3t_pkg::FIFO_DEPTH))
    else $error("input stalled with too few results outstanding");

endmodule

bind conv3x3_threshold_unit c3t_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_pixel (res_out.out_pixel),
  .frame_last(res_out.frame_last)
);
